// File: rtl/core/fgm_pkg.sv
// Shared constants and types for the Fibonacci-of-gcd modular core.
`default_nettype none
package fgm_pkg;
  localparam int unsigned IndexWidthDef   = 63;
  localparam int unsigned ModulusWidthDef = 31;

  // Top-level sequencer states (one-hot)
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_GCD   = 6'b000010,
    ST_POW   = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_WAIT  = 6'b010000,
    ST_DONE  = 6'b100000
  } fgm_state_e;
endpackage
`default_nettype wire

// File: rtl/core/fgm_divider.sv
// Bit-serial restoring divider: remainder of a by b, one quotient bit per cycle.
`default_nettype none
module fgm_divider #(
  parameter int unsigned W = 63
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              done_o,
  output logic [W-1:0]      rem_o
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  num_q, num_d;
  logic [W-1:0]  div_q, div_d;
  logic [W:0]    rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          run_q, run_d;
  logic          done_q, done_d;
  logic [W:0]    trial;
  logic [W:0]    diff;

  // One shift-subtract step
  assign trial = {rem_q[W-1:0], num_q[W-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    num_d  = num_q;
    div_d  = div_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d = dividend_i;
      div_d = divisor_i;
      rem_d = '0;
      cnt_d = CW'(W);
      run_d = 1'b1;
    end else if (run_q) begin
      num_d = {num_q[W-2:0], 1'b0};
      rem_d = diff[W] ? trial : diff;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[W-1:0];

  // A step never leaves a remainder at or above the divisor
  property p_rem_bound;
    @(posedge clk_i) disable iff (!rst_ni) done_q |-> (rem_q < {1'b0, div_q});
  endproperty
  a_rem_bound: assert property (p_rem_bound) else $error("remainder out of range");

  property p_done_pulse;
    @(posedge clk_i) disable iff (!rst_ni) done_q |=> !done_q;
  endproperty
  a_done_pulse: assert property (p_done_pulse) else $error("done held");
endmodule
`default_nettype wire

// File: rtl/core/fgm_modmul.sv
// Bit-serial modular multiply-add: (acc + x*y) mod m, one bit of y per cycle.
`default_nettype none
module fgm_modmul #(
  parameter int unsigned W = 31
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] acc_i,
  input  wire logic [W-1:0] x_i,
  input  wire logic [W-1:0] y_i,
  input  wire logic [W-1:0] mod_i,
  output logic              done_o,
  output logic [W-1:0]      res_o
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  x_q, x_d;
  logic [W-1:0]  y_q, y_d;
  logic [W-1:0]  m_q, m_d;
  logic [W-1:0]  r_q, r_d;
  logic [W-1:0]  a_q, a_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          run_q, run_d;
  logic          done_q, done_d;
  logic [W:0]    dbl, dblr, addv, addr;

  // Horner step: r = 2r mod m, then add x if the bit is set
  assign dbl  = {r_q, 1'b0};
  assign dblr = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
  assign addv = dblr + (y_q[W-1] ? {1'b0, x_q} : '0);
  assign addr = (addv >= {1'b0, m_q}) ? addv - {1'b0, m_q} : addv;

  always_comb begin
    x_d = x_q; y_d = y_q; m_d = m_q; r_d = r_q; a_d = a_q;
    cnt_d = cnt_q; run_d = run_q; done_d = 1'b0;
    if (start_i) begin
      x_d = x_i; y_d = y_i; m_d = mod_i; a_d = acc_i;
      r_d = '0; cnt_d = CW'(W); run_d = 1'b1;
    end else if (run_q) begin
      if (cnt_q == '0) begin
        // final add of the accumulator term
        r_d    = addv[W-1:0];
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        r_d   = addr[W-1:0];
        y_d   = {y_q[W-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          x_d = a_q;
          y_d = {1'b1, {(W-1){1'b0}}};
          r_d = addr[W-1:0];
        end
      end
    end
  end

  // The last step adds the accumulator to r on its own adder, without doubling
  logic [W:0] fin, finr;
  assign fin  = {1'b0, r_q} + {1'b0, a_q};
  assign finr = (fin >= {1'b0, m_q}) ? fin - {1'b0, m_q} : fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      run_q <= run_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; m_q <= m_d; a_q <= a_d;
    if (run_q && cnt_q == '0) begin
      r_q <= finr[W-1:0];
    end else begin
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = r_q;

  property p_res_bound;
    @(posedge clk_i) disable iff (!rst_ni) done_q |-> (r_q < m_q);
  endproperty
  a_res_bound: assert property (p_res_bound) else $error("product not reduced");
endmodule
`default_nettype wire

// File: rtl/core/fibonacci_of_gcd_mod_core.sv
// Top level: Euclid gcd on a serial divider, then matrix power on a serial mod multiplier.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------------
//  input   | index_a_i, index_b_i, modulus_i         | start_i high, busy_o low
//  result  | fib_gcd_mod_o                           | done_o one-cycle strobe
//
// Each remainder step of Euclid runs on the single divider (up to about 92 steps);
// each modular multiply-add runs on the serial multiplier, and the power runs 8 or
// 16 of them per index bit of g. One item is worked on at a time; busy_o stays high
// from acceptance until the result strobe. Reset clears only the control state of
// the sequencer, divider and multiplier. The receiver cannot stall the result.
`default_nettype none
module fibonacci_of_gcd_mod_core #(
  parameter int unsigned INDEX_WIDTH   = fgm_pkg::IndexWidthDef,
  parameter int unsigned MODULUS_WIDTH = fgm_pkg::ModulusWidthDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic [INDEX_WIDTH-1:0]   index_a_i,
  input  wire logic [INDEX_WIDTH-1:0]   index_b_i,
  input  wire logic [MODULUS_WIDTH-1:0] modulus_i,
  output logic                          done_o,
  output logic [MODULUS_WIDTH-1:0]      fib_gcd_mod_o
);
  import fgm_pkg::*;

  localparam int unsigned IW = INDEX_WIDTH;
  localparam int unsigned MW = MODULUS_WIDTH;
  localparam int unsigned BW = $clog2(IW);

  fgm_state_e     st_q, st_d;
  logic [IW-1:0]  a_q, a_d, b_q, b_d;
  logic [MW-1:0]  m_q, m_d;
  // accumulator matrix entries and temporaries
  logic [MW-1:0]  e00_q, e01_q, e10_q, e11_q;
  logic [MW-1:0]  t_q [4];
  logic [BW-1:0]  bit_q, bit_d;
  logic           sq_q, sq_d;     // 1: squaring pass, 0: multiply by base
  logic [2:0]     op_q, op_d;     // which of 8 multiply-adds
  logic           dv_start, mm_start;
  logic           dv_done, mm_done;
  logic [IW-1:0]  dv_rem;
  logic [MW-1:0]  mm_res;
  logic [MW-1:0]  mx, my, macc;
  logic           res_zero;
  logic           done_q;
  logic [MW-1:0]  res_q;

  fgm_divider #(.W(IW)) u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .dividend_i(a_q), .divisor_i(b_q),
    .done_o(dv_done), .rem_o(dv_rem)
  );

  fgm_modmul #(.W(MW)) u_mul (
    .clk_i, .rst_ni, .start_i(mm_start), .acc_i(macc), .x_i(mx), .y_i(my),
    .mod_i(m_q), .done_o(mm_done), .res_o(mm_res)
  );

  // Operand select: op[2:1] = entry (ij), op[0] = k term
  logic [1:0] ent;
  logic       kk;
  logic [MW-1:0] xi0, xi1, y0j, y1j, one_m;
  assign ent   = op_q[2:1];
  assign kk    = op_q[0];
  assign one_m = (m_q == MW'(1)) ? '0 : MW'(1);

  always_comb begin
    xi0 = ent[1] ? e10_q : e00_q;
    xi1 = ent[1] ? e11_q : e01_q;
    if (sq_q) begin
      y0j = ent[0] ? e01_q : e00_q;
      y1j = ent[0] ? e11_q : e10_q;
    end else begin
      // base [[1,1],[1,0]] reduced
      y0j = one_m;
      y1j = ent[0] ? '0 : one_m;
    end
    mx   = kk ? xi1 : xi0;
    my   = kk ? y1j : y0j;
    macc = kk ? t_q[ent] : '0;
  end

  assign res_zero = (m_q == '0);

  always_comb begin
    st_d = st_q; a_d = a_q; b_d = b_q; m_d = m_q;
    bit_d = bit_q; sq_d = sq_q; op_d = op_q;
    dv_start = 1'b0; mm_start = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (start_i) begin
          a_d = index_a_i; b_d = index_b_i; m_d = modulus_i;
          st_d = ST_GCD;
        end
      end
      ST_GCD: begin
        if (b_q == '0) begin
          st_d = ST_POW; bit_d = BW'(IW - 1); sq_d = 1'b1; op_d = '0;
        end else begin
          dv_start = 1'b1; st_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (dv_done) begin
          a_d = b_q; b_d = dv_rem; st_d = ST_GCD;
        end
      end
      ST_POW: begin
        if (res_zero) begin
          st_d = ST_DONE;
        end else if (!sq_q && !a_q[bit_q]) begin
          // skip the base multiply for a zero bit
          if (bit_q == '0) st_d = ST_DONE;
          else begin bit_d = bit_q - 1'b1; sq_d = 1'b1; end
        end else begin
          mm_start = 1'b1; st_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mm_done) begin
          if (op_q == 3'd7) begin
            op_d = '0;
            if (sq_q) sq_d = 1'b0;
            else if (bit_q == '0) st_d = ST_DONE;
            else begin bit_d = bit_q - 1'b1; sq_d = 1'b1; end
            if (!(sq_q == 1'b0 && bit_q == '0)) st_d = ST_POW;
          end else begin
            op_d = op_q + 1'b1; st_d = ST_POW;
          end
        end
      end
      ST_DONE: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; done_q <= 1'b0;
    end else begin
      st_q <= st_d; done_q <= (st_q == ST_DONE);
    end
  end

  // Datapath: matrix registers and temporaries
  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; m_q <= m_d; bit_q <= bit_d; sq_q <= sq_d; op_q <= op_d;
    if (st_q == ST_GCD && b_q == '0) begin
      e00_q <= one_m; e01_q <= '0; e10_q <= '0; e11_q <= one_m;
    end
    if (st_q == ST_MUL && mm_done) begin
      t_q[ent] <= mm_res;
      if (op_q == 3'd7) begin
        e00_q <= t_q[0]; e01_q <= t_q[1]; e10_q <= t_q[2]; e11_q <= mm_res;
      end
    end
    if (st_q == ST_DONE) res_q <= res_zero ? '0 : e01_q;
  end

  assign busy_o        = (st_q != ST_IDLE);
  assign done_o        = done_q;
  assign fib_gcd_mod_o = res_q;

  property p_done_after;
    @(posedge clk_i) disable iff (!rst_ni) done_q |-> $past(st_q == ST_DONE);
  endproperty
  a_done_after: assert property (p_done_after) else $error("stray result");

  property p_no_accept_busy;
    @(posedge clk_i) disable iff (!rst_ni) (st_q != ST_IDLE) |-> busy_o;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("busy dropped");

  property p_res_range;
    @(posedge clk_i) disable iff (!rst_ni)
      (done_q && m_q != '0) |-> (res_q < m_q);
  endproperty
  a_res_range: assert property (p_res_range) else $error("result not reduced");
endmodule
`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for fibonacci_of_gcd_mod_core: directed table, then random items.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IW = fgm_pkg::IndexWidthDef;
  localparam int unsigned MW = fgm_pkg::ModulusWidthDef;
  localparam int unsigned NumRandom = 83;

  typedef logic [IW-1:0] index_t;
  typedef logic [MW-1:0] mod_t;

  typedef struct {
    index_t a;
    index_t b;
    mod_t   m;
    bit     typed;  // fib holds a hand-written value
    mod_t   fib;
  } stim_row_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start_i = 1'b0;
  index_t index_a_i = '0;
  index_t index_b_i = '0;
  mod_t   modulus_i = '0;
  logic   busy_o;
  logic   done_o;
  mod_t   fib_gcd_mod_o;

  mod_t      fib_expected_q[$];
  stim_row_t rows[$];
  int   fail_count = 0;
  int   items_sent = 0;
  int   results_seen = 0;
  int   zero_mod_items = 0;

  fibonacci_of_gcd_mod_core dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .busy_o(busy_o),
    .index_a_i(index_a_i),
    .index_b_i(index_b_i),
    .modulus_i(modulus_i),
    .done_o(done_o),
    .fib_gcd_mod_o(fib_gcd_mod_o)
  );

  always #5 clk_i = ~clk_i;

  // 2x2 matrix product with every entry reduced after each multiply-add
  function automatic void mat_mul_mod(input longint unsigned x[4], input longint unsigned y[4],
                                      input longint unsigned m, output longint unsigned r[4]);
    longint unsigned acc;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        acc = 0;
        for (int k = 0; k < 2; k++) begin
          acc = acc + x[2*i+k] * y[2*k+j];
          acc = acc % m;
        end
        r[2*i+j] = acc;
      end
    end
  endfunction

  // F(gcd(a, b)) mod m by Euclid and square-and-multiply over all 64 bits
  function automatic mod_t fib_of_gcd(input index_t a, input index_t b, input mod_t m);
    longint unsigned x, y, t, g, mm;
    longint unsigned acc[4], base[4], tmp[4];
    x = a;
    y = b;
    mm = m;
    if (mm == 0) return '0;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    g = x;
    acc = '{1 % mm, 0, 0, 1 % mm};
    base = '{1 % mm, 1 % mm, 1 % mm, 0};
    for (int bitpos = 63; bitpos >= 0; bitpos--) begin
      mat_mul_mod(acc, acc, mm, tmp);
      acc = tmp;
      if (g[bitpos]) begin
        mat_mul_mod(acc, base, mm, tmp);
        acc = tmp;
      end
    end
    return mod_t'(acc[1]);
  endfunction

  // Append one row to the directed table
  function automatic void add_row(input stim_row_t r);
    rows = {rows, r};
  endfunction

  // Present one item and hold it until accepted; start stays high for the caller
  task automatic send_item(input index_t a, input index_t b, input mod_t m,
                           input bit typed, input mod_t fib);
    mod_t expected_fib;
    start_i <= 1'b1;
    index_a_i <= a;
    index_b_i <= b;
    modulus_i <= m;
    do @(posedge clk_i); while (busy_o);
    expected_fib = typed ? fib : fib_of_gcd(a, b, m);
    fib_expected_q = {fib_expected_q, expected_fib};
    items_sent++;
    if (m == '0) zero_mod_items++;
  endtask

  // Sender idles in bursts: most items go back to back, some after a random gap
  task automatic maybe_gap();
    int gap;
    if ($urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 40);
      start_i <= 1'b0;
      index_a_i <= index_t'({$urandom, $urandom});
      index_b_i <= index_t'({$urandom, $urandom});
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Result checker: each strobe against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      results_seen++;
      if (fib_expected_q.size() == 0) begin
        $display("%0t: unexpected result fib_gcd_mod=%0d", $time, fib_gcd_mod_o);
        fail_count++;
      end else begin
        if (fib_gcd_mod_o !== fib_expected_q[0]) begin
          $display("%0t: fib_gcd_mod expected %0d actual %0d", $time, fib_expected_q[0],
                   fib_gcd_mod_o);
          fail_count++;
        end
        void'(fib_expected_q.pop_front());
      end
    end
  end

  initial begin
    index_t a, b, g;
    mod_t m;
    int wait_cycles;

    // Directed rows: extremes and special cases
    add_row('{'0, '0, 31'd1000, 1'b1, 31'd0});              // both indices zero
    add_row('{63'd1, 63'd1, 31'd1, 1'b1, 31'd0});           // modulus one, g of one
    add_row('{63'd5, 63'd7, 31'd0, 1'b1, 31'd0});           // modulus zero
    add_row('{'1, '1, '0, 1'b1, 31'd0});                    // max indices, zero mod
    add_row('{63'd1, 63'd0, '1, 1'b1, 31'd1});              // g of one
    add_row('{'0, 63'd1, '1, 1'b1, 31'd1});
    add_row('{63'd12, 63'd18, 31'd1000, 1'b1, 31'd8});      // F(6)
    add_row('{63'd2, 63'd4, '1, 1'b1, 31'd1});              // F(2)
    add_row('{63'd30, 63'd0, 31'd2, 1'b0, '0});
    add_row('{'1, '1, '1, 1'b0, '0});
    add_row('{'1, '0, '1, 1'b0, '0});
    add_row('{'0, '1, 31'd97, 1'b0, '0});
    add_row('{63'h4000_0000_0000_0000, 63'h2000_0000_0000_0000, '1, 1'b0, '0});
    add_row('{63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 31'h5555_5555,
              1'b0, '0});
    add_row('{'1, 63'h7FFF_FFFF_FFFF_FFFE, 31'h2AAA_AAAA, 1'b0, '0});
    add_row('{63'd7540113804746346429, 63'd4660046610375530309, 31'd1000000007,
              1'b0, '0});                                   // consecutive Fibonacci
    add_row('{63'd100, 63'd90, 31'd3, 1'b0, '0});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      send_item(rows[i].a, rows[i].b, rows[i].m, rows[i].typed, rows[i].fib);
      if (i % 5 == 4) maybe_gap();
    end

    // Random items: half of them index pairs with a planted common factor
    for (int n = 0; n < NumRandom; n++) begin
      case ($urandom_range(0, 3))
        0: begin
          a = index_t'({$urandom, $urandom});
          b = index_t'({$urandom, $urandom});
        end
        1: begin
          g = index_t'($urandom_range(1, 2000));
          a = g * $urandom_range(0, 1 << 20);
          b = g * $urandom_range(0, 1 << 20);
        end
        2: begin
          g = index_t'({$urandom, $urandom} >> $urandom_range(0, 62));
          a = g * $urandom_range(0, 3);
          b = g * $urandom_range(1, 3);
        end
        default: begin
          a = index_t'($urandom_range(0, 200));
          b = index_t'($urandom_range(0, 200));
        end
      endcase
      case ($urandom_range(0, 3))
        0: m = mod_t'($urandom_range(0, 10));
        1: m = mod_t'($urandom_range(11, 100000));
        default: m = mod_t'($urandom);
      endcase
      send_item(a, b, m, 1'b0, '0);
      maybe_gap();
    end
    start_i <= 1'b0;

    // Drain, then a short quiet period
    wait_cycles = 0;
    while (fib_expected_q.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (100) @(posedge clk_i);
    if (fib_expected_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, fib_expected_q.size());
      fail_count++;
    end

    $display("Covered %0d items (%0d directed, %0d with zero modulus), %0d results checked.",
             items_sent, rows.size(), zero_mod_items, results_seen);
    if (fail_count == 0) begin
      $display("fibonacci_of_gcd_mod_core regression: pass");
    end else begin
      $display("fibonacci_of_gcd_mod_core regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #400ms;
    $display("fibonacci_of_gcd_mod_core regression: fail");
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
rtl/core/fgm_pkg.sv
rtl/core/fgm_divider.sv
rtl/core/fgm_modmul.sv
rtl/core/fibonacci_of_gcd_mod_core.sv
sim/tb_top.sv
